@@ sv/assert_macros.svh @@
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/pfa_pkg.sv @@
// Shared types and codes for the paged frame allocator
`default_nettype none
package pfa_pkg;
  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_RESIZE  = 3'd2;
  localparam logic [2:0] ACT_LOOKUP  = 3'd3;
  localparam logic [2:0] ACT_ACCESS  = 3'd4;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_PID  = 3'd1;
  localparam logic [2:0] ST_ADDR = 3'd2;
  localparam logic [2:0] ST_OOM  = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  localparam logic [7:0] NO_FRAME = 8'hFF;
  localparam logic [1:0] REG_PAGE_SHIFT = 2'd0;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  pid;
    logic [6:0]  page_index;
    logic [18:0] address;
    logic [15:0] length;
    logic [19:0] new_size;
  } req_t;

  function automatic logic [3:0] eff_shift(input logic [3:0] s);
    if (s < 4'd4) return 4'd4;
    if (s > 4'd12) return 4'd12;
    return s;
  endfunction
endpackage
`default_nettype wire

@@ sv/pfa_bitmap.sv @@
// Used-frame bitmap memory, one bit per frame, with a registered read port
`default_nettype none
module pfa_bitmap #(
  parameter int NUM_FRAMES = 128,
  localparam int FW = $clog2(NUM_FRAMES)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [FW-1:0] rd_addr,
  output logic               rd_data,
  input  wire logic          wr_en,
  input  wire logic [FW-1:0] wr_addr,
  input  wire logic          wr_data
);
  logic mem [NUM_FRAMES];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ sv/pfa_table.sv @@
// Page table memory, one row of NUM_FRAMES entries per process
`default_nettype none
module pfa_table #(
  parameter int DEPTH = 2048,
  parameter int DW = 7,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ sv/paged_frame_allocator.sv @@
// Paged frame allocator: the top level, its sequencer and register port
// One request at a time (busy); resize, release and access walk the page table or
// the bitmap. Table and bitmap walks read each entry, then check or write it back.
// After rst the bitmap is cleared frame by frame while busy stays high.
// The result is shown for one cycle on done; the receiver cannot stall.
`default_nettype none
module paged_frame_allocator #(
  parameter int NUM_FRAMES = 128,
  parameter int MAX_PROCS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [3:0]  pid,
  input  wire logic [6:0]  page_index,
  input  wire logic [18:0] address,
  input  wire logic [15:0] length,
  input  wire logic [19:0] new_size,
  output logic             done,
  output logic [2:0]       status,
  output logic signed [7:0] frame,
  output logic [12:0]      granted_length,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pfa_pkg::*;
  `include "assert_macros.svh"

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int PW = $clog2(MAX_PROCS);
  localparam int CW = FW + 1;
  localparam int TAW = PW + FW;
  localparam logic [CW-1:0] NF = CW'(NUM_FRAMES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SHRINK_RD, S_SHRINK_WR, S_GROW_RD, S_GROW_CHK,
    S_LOOK_RD, S_LOOK_WT, S_ACC_RD, S_ACC_CHK, S_DONE
  } state_t;

  state_t state;
  req_t req;
  logic [3:0] page_shift;
  logic [MAX_PROCS-1:0] live;
  logic [CW-1:0] pcount [MAX_PROCS];
  logic [CW-1:0] free_frames;
  logic [CW-1:0] target_cnt, idx;
  logic [FW-1:0] scan;
  logic [2:0] r_status;
  logic [7:0] r_frame;
  logic [12:0] r_grant;
  logic release_op;

  // memory ports
  logic bm_rd_en, bm_rd_data, bm_wr_en, bm_wr_data;
  logic [FW-1:0] bm_rd_addr, bm_wr_addr;
  logic [TAW-1:0] pt_rd_addr, pt_wr_addr;
  logic [FW-1:0] pt_rd_data, pt_wr_data;
  logic pt_wr_en;

  pfa_bitmap #(.NUM_FRAMES(NUM_FRAMES)) u_bitmap (
    .clk, .rd_en(bm_rd_en), .rd_addr(bm_rd_addr), .rd_data(bm_rd_data),
    .wr_en(bm_wr_en), .wr_addr(bm_wr_addr), .wr_data(bm_wr_data)
  );
  pfa_table #(.DEPTH(MAX_PROCS * NUM_FRAMES), .DW(FW)) u_table (
    .clk, .rd_addr(pt_rd_addr), .rd_data(pt_rd_data),
    .wr_en(pt_wr_en), .wr_addr(pt_wr_addr), .wr_data(pt_wr_data)
  );

  logic [PW-1:0] p;
  logic [3:0] sh;
  logic [19:0] smask;
  logic [20:0] need_w;
  logic [CW-1:0] need;
  logic [CW-1:0] cur;
  logic [18:0] tgt_w;
  logic [19:0] room_w;
  logic addr_fits;

  always_comb begin
    p = PW'(req.pid);
    sh = eff_shift(page_shift);
    smask = (20'd1 << sh) - 20'd1;
    need_w = 21'(req.new_size >> sh) + 21'((req.new_size & smask) != 20'd0);
    need = (need_w > 21'(NUM_FRAMES)) ? NF : CW'(need_w);
    cur = pcount[p];
    tgt_w = req.address >> sh;
    addr_fits = tgt_w < 19'(NUM_FRAMES);
    room_w = ((20'(tgt_w) + 20'd1) << sh) - 20'(req.address);
  end

  // need beyond NUM_FRAMES is always out of memory since need-cur > free
  logic need_big;
  assign need_big = need_w > 21'(NUM_FRAMES);

  always_comb begin
    bm_rd_en = 1'b0;
    bm_rd_addr = scan;
    bm_wr_en = 1'b0;
    bm_wr_addr = scan;
    bm_wr_data = 1'b0;
    pt_rd_addr = {p, FW'(idx)};
    pt_wr_en = 1'b0;
    pt_wr_addr = {p, FW'(idx)};
    pt_wr_data = scan;
    unique case (state)
      S_CLEAR: bm_wr_en = 1'b1;
      S_SHRINK_RD: pt_rd_addr = {p, FW'(idx - 1'b1)};
      S_SHRINK_WR: begin
        bm_wr_en = 1'b1;
        bm_wr_addr = pt_rd_data;
      end
      S_GROW_RD: bm_rd_en = 1'b1;
      S_GROW_CHK: begin
        if (!bm_rd_data) begin
          bm_wr_en = 1'b1;
          bm_wr_data = 1'b1;
          pt_wr_en = 1'b1;
        end
      end
      S_LOOK_RD: pt_rd_addr = {p, FW'(req.page_index)};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      scan <= '0;
      live <= '0;
      for (int i = 0; i < MAX_PROCS; i++) pcount[i] <= '0;
      free_frames <= NF;
      page_shift <= 4'd5;
    end else begin
      if (psel && penable && pwrite && paddr == REG_PAGE_SHIFT) page_shift <= pwdata[3:0];
      unique case (state)
        S_CLEAR: begin
          scan <= scan + 1'b1;
          if (scan == FW'(NUM_FRAMES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req <= '{action, pid, page_index, address, length, new_size};
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          r_status <= ST_OK;
          r_frame <= NO_FRAME;
          r_grant <= '0;
          release_op <= 1'b0;
          state <= S_DONE;
          if (req.action > ACT_ACCESS) r_status <= ST_ERR;
          else if (32'(req.pid) >= MAX_PROCS) r_status <= ST_PID;
          else if (req.action == ACT_CREATE) begin
            if (live[p]) r_status <= ST_ERR;
            else begin
              live[p] <= 1'b1;
              pcount[p] <= '0;
            end
          end else if (!live[p]) r_status <= ST_PID;
          else begin
            unique case (req.action)
              ACT_RELEASE: begin
                release_op <= 1'b1;
                target_cnt <= '0;
                idx <= cur;
                state <= S_SHRINK_RD;
              end
              ACT_RESIZE: begin
                idx <= cur;
                target_cnt <= need;
                scan <= '0;
                if (need < cur) state <= S_SHRINK_RD;
                else if (need_big || (need - cur) > free_frames) r_status <= ST_OOM;
                else state <= S_GROW_RD;
              end
              ACT_LOOKUP: begin
                if (32'(req.page_index) < 32'(cur)) state <= S_LOOK_RD;
              end
              default: begin
                idx <= '0;
                if (!addr_fits) r_status <= ST_ADDR;
                else state <= S_ACC_RD;
              end
            endcase
          end
        end
        S_SHRINK_RD: begin
          if (idx == target_cnt) begin
            pcount[p] <= idx;
            if (release_op) live[p] <= 1'b0;
            state <= S_DONE;
          end else state <= S_SHRINK_WR;
        end
        S_SHRINK_WR: begin
          free_frames <= free_frames + 1'b1;
          idx <= idx - 1'b1;
          state <= S_SHRINK_RD;
        end
        S_GROW_RD: begin
          if (idx == target_cnt) begin
            pcount[p] <= idx;
            state <= S_DONE;
          end else state <= S_GROW_CHK;
        end
        S_GROW_CHK: begin
          if (!bm_rd_data) begin
            free_frames <= free_frames - 1'b1;
            idx <= idx + 1'b1;
          end
          scan <= scan + 1'b1;
          state <= S_GROW_RD;
        end
        S_LOOK_RD: state <= S_LOOK_WT;
        S_LOOK_WT: begin
          r_frame <= 8'(pt_rd_data);
          state <= S_DONE;
        end
        S_ACC_RD: begin
          if (idx == cur) begin
            r_status <= ST_ADDR;
            state <= S_DONE;
          end else state <= S_ACC_CHK;
        end
        S_ACC_CHK: begin
          if (19'(pt_rd_data) == tgt_w) begin
            r_frame <= 8'(tgt_w);
            r_grant <= (20'(req.length) < room_w) ? 13'(req.length) : 13'(room_w);
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_ACC_RD;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          status <= r_status;
          frame <= r_frame;
          granted_length <= r_grant;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PAGE_SHIFT) ? {28'd0, page_shift} : 32'd0;

  `ASSERT_NXT(a_done_one, clk, rst, done, !done, "result strobe longer than one cycle")
  `ASSERT_IMP(a_free_bound, clk, rst, 1'b1, free_frames <= NF, "free count above pool size")
  `ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy, "request not taken")
  `ASSERT_IMP(a_grow_space, clk, rst, state == S_GROW_CHK && !bm_rd_data,
    free_frames != '0, "allocation with no free frame")
endmodule
`default_nettype wire

@@ bench/tb_paged_frame_allocator.sv @@
// Self-checking bench for the paged frame allocator: request driver, result monitor, predictor
`default_nettype none
module tb_paged_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int NFR = 128;
  localparam int NPROC = 16;
  localparam int SETTLE = 280;

  typedef struct {
    bit          is_cfg;
    logic [31:0] cfg;
    req_t        r;
    bit          calm;
  } job_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  frame;
    logic [12:0] granted;
  } reply_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  action = '0;
  logic [3:0]  pid = '0;
  logic [6:0]  page_index = '0;
  logic [18:0] address = '0;
  logic [15:0] length = '0;
  logic [19:0] new_size = '0;
  logic        done;
  logic [2:0]  status;
  logic signed [7:0] frame;
  logic [12:0] granted_length;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  paged_frame_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .pid(pid), .page_index(page_index), .address(address),
    .length(length), .new_size(new_size), .done(done), .status(status),
    .frame(frame), .granted_length(granted_length), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // allocator shadow state
  logic [3:0] shift_cfg = 4'd5;
  bit         live [NPROC];
  int         pages [NPROC];
  logic [6:0] ptab [NPROC][NFR];
  bit         used [NFR];
  int         nfree = NFR;

  job_t   pending [$];
  reply_t awaited [$];
  int     errs = 0;
  int     gen_sh = 5;
  bit     taken = 0;
  int     gap = 0;
  int     settle = 0;
  int     cfg_step = 0;
  job_t   cur;

  function automatic void drop_pages(int p, int keep);
    int f;
    while (pages[p] > keep) begin
      f = ptab[p][pages[p] - 1];
      if (used[f]) begin
        used[f] = 0;
        nfree++;
      end
      pages[p]--;
    end
  endfunction

  function automatic reply_t serve_request(req_t r);
    reply_t o;
    int sh, need, f, tgt, room, i;
    bit hit;
    o.status = ST_OK;
    o.frame = NO_FRAME;
    o.granted = '0;
    sh = shift_cfg < 4 ? 4 : (shift_cfg > 12 ? 12 : int'(shift_cfg));
    if (r.action > ACT_ACCESS) begin
      o.status = ST_ERR;
    end else if (r.pid >= NPROC) begin
      o.status = ST_PID;
    end else if (r.action == ACT_CREATE) begin
      if (live[r.pid]) o.status = ST_ERR;
      else begin
        live[r.pid] = 1;
        pages[r.pid] = 0;
      end
    end else if (!live[r.pid]) begin
      o.status = ST_PID;
    end else if (r.action == ACT_RELEASE) begin
      drop_pages(r.pid, 0);
      live[r.pid] = 0;
    end else if (r.action == ACT_RESIZE) begin
      need = (int'(r.new_size) >> sh) + ((int'(r.new_size) & ((1 << sh) - 1)) != 0);
      if (need < pages[r.pid]) drop_pages(r.pid, need);
      else if (need - pages[r.pid] > nfree) o.status = ST_OOM;
      else begin
        while (pages[r.pid] < need && pages[r.pid] < NFR) begin
          f = 0;
          while (f < NFR - 1 && used[f]) f++;  // lowest free frame first
          used[f] = 1;
          nfree--;
          ptab[r.pid][pages[r.pid]] = f[6:0];
          pages[r.pid]++;
        end
      end
    end else if (r.action == ACT_LOOKUP) begin
      if (r.page_index < pages[r.pid]) o.frame = {1'b0, ptab[r.pid][r.page_index]};
    end else begin
      tgt = int'(r.address) >> sh;
      hit = 0;
      for (i = 0; i < pages[r.pid] && !hit; i++)
        if (int'(ptab[r.pid][i]) == tgt) hit = 1;
      if (!hit) o.status = ST_ADDR;
      else begin
        room = ((tgt + 1) << sh) - int'(r.address);
        o.frame = tgt[7:0];
        o.granted = (int'(r.length) < room) ? r.length[12:0] : room[12:0];
      end
    end
    return o;
  endfunction

  // monitor: config commits, request acceptance and result checks
  always @(posedge clk) begin
    taken <= start && !busy;
    if (!rst) begin
      if (done) begin
        if (awaited.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          reply_t e;
          e = awaited.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errs++;
          end
          if (frame !== e.frame) begin
            $error("frame: expected %0d, got %0d", $signed(e.frame), frame);
            errs++;
          end
          if (granted_length !== e.granted) begin
            $error("granted_length: expected %0d, got %0d", e.granted, granted_length);
            errs++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_PAGE_SHIFT)
        shift_cfg = pwdata[3:0];
      if (start && !busy)
        awaited.push_back(serve_request('{action, pid, page_index, address, length,
                                          new_size}));
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (start && !taken) begin
      // request still waiting for acceptance
    end else if (cfg_step == 2) begin
      penable <= 1;
      cfg_step = 3;
    end else if (cfg_step == 3) begin
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      cfg_step = 0;
      void'(pending.pop_front());
    end else if (gap > 0) begin
      start <= 0;
      gap--;
    end else if (pending.size() == 0) begin
      start <= 0;
    end else if (pending[0].is_cfg) begin
      start <= 0;
      // block idle: let any trailing work drain before touching the register
      if (awaited.size() == 0 && !busy && !start) begin
        if (settle < SETTLE) settle++;
        else begin
          settle = 0;
          psel <= 1;
          penable <= 0;
          pwrite <= 1;
          paddr <= REG_PAGE_SHIFT;
          pwdata <= pending[0].cfg;
          cfg_step = 2;
        end
      end
    end else begin
      cur = pending.pop_front();
      start <= 1;
      action <= cur.r.action;
      pid <= cur.r.pid;
      page_index <= cur.r.page_index;
      address <= cur.r.address;
      length <= cur.r.length;
      new_size <= cur.r.new_size;
      if (!cur.calm && $urandom_range(0, 1)) gap = $urandom_range(1, 8);
    end
  end

  task automatic add_req(logic [2:0] a, logic [3:0] p, logic [6:0] pi, logic [18:0] ad,
                         logic [15:0] ln, logic [19:0] sz, bit calm = 0);
    job_t j;
    j.is_cfg = 0;
    j.cfg = '0;
    j.r = '{a, p, pi, ad, ln, sz};
    j.calm = calm;
    pending.push_back(j);
  endtask

  task automatic add_cfg(logic [31:0] v);
    job_t j;
    j.is_cfg = 1;
    j.cfg = v;
    j.r = '0;
    j.calm = 0;
    pending.push_back(j);
    gen_sh = v[3:0] < 4 ? 4 : (v[3:0] > 12 ? 12 : int'(v[3:0]));
  endtask

  task automatic add_random(bit calm);
    int sel, pg;
    logic [2:0]  a;
    logic [3:0]  p;
    logic [6:0]  pi;
    logic [18:0] ad;
    logic [15:0] ln;
    logic [19:0] sz;
    sel = $urandom_range(0, 99);
    if (sel < 8) a = ACT_CREATE;
    else if (sel < 14) a = ACT_RELEASE;
    else if (sel < 40) a = ACT_RESIZE;
    else if (sel < 65) a = ACT_LOOKUP;
    else if (sel < 97) a = ACT_ACCESS;
    else a = 3'($urandom_range(5, 7));
    p = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
    pi = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 31));
    if ($urandom_range(0, 7) == 0) ad = 19'($urandom);
    else ad = 19'(($urandom_range(0, 60) << gen_sh) | $urandom_range(0, (1 << gen_sh) - 1));
    ln = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64));
    if ($urandom_range(0, 9) == 0) sz = 20'($urandom_range(0, 524288));
    else begin
      pg = $urandom_range(0, 30);
      sz = 20'(pg << gen_sh);
      if (pg > 0 && $urandom_range(0, 1)) sz = sz - 20'($urandom_range(0, (1 << gen_sh) - 1));
    end
    add_req(a, p, pi, ad, ln, sz, calm);
  endtask

  initial begin
    int k;
    // directed part at the reset page size of 32 bytes
    add_req(ACT_CREATE, 0, 0, 0, 0, 0);
    add_req(ACT_CREATE, 0, 0, 0, 0, 0);                    // create on live pid
    add_req(3'd5, 0, 0, 0, 0, 0);
    add_req(3'd6, 0, 0, 0, 0, 0);
    add_req(3'd7, 15, 127, 19'h7FFFF, 16'hFFFF, 20'hFFFFF);
    add_req(ACT_RELEASE, 3, 0, 0, 0, 0);                   // not live
    add_req(ACT_LOOKUP, 3, 0, 0, 0, 0);
    add_req(ACT_ACCESS, 3, 0, 0, 0, 0);
    add_req(ACT_RESIZE, 3, 0, 0, 0, 64);
    add_req(ACT_RESIZE, 0, 0, 0, 0, 20'd524288);           // out of memory
    add_req(ACT_RESIZE, 0, 0, 0, 0, 4096);                 // whole pool
    add_req(ACT_CREATE, 15, 0, 0, 0, 0);
    add_req(ACT_RESIZE, 15, 0, 0, 0, 32);                  // no frame left
    add_req(ACT_LOOKUP, 0, 0, 0, 0, 0);
    add_req(ACT_LOOKUP, 0, 127, 0, 0, 0);
    add_req(ACT_ACCESS, 0, 0, 19'h7FFFF, 16'hFFFF, 0);     // in no frame
    add_req(ACT_ACCESS, 0, 0, (5 << 5) + 3, 16'hFFFF, 0);  // clamped to page end
    add_req(ACT_ACCESS, 0, 0, 127 << 5, 0, 0);
    add_req(ACT_RESIZE, 0, 0, 0, 0, 4000);                 // shrink
    add_req(ACT_RESIZE, 0, 0, 0, 0, 3969);                 // same page count
    add_req(ACT_LOOKUP, 0, 125, 0, 0, 0);                  // beyond page count
    add_req(ACT_RESIZE, 15, 0, 0, 0, 96);
    add_req(ACT_LOOKUP, 15, 2, 0, 0, 0);
    add_req(ACT_RELEASE, 0, 0, 0, 0, 0);
    add_req(ACT_RELEASE, 15, 0, 0, 0, 0);
    add_cfg(32'hFFFF_FFF0);                                // below range: acts as 4
    for (k = 0; k < 270; k++) add_random(0);
    add_cfg(32'd15);                                       // above range: acts as 12
    for (k = 0; k < 270; k++) add_random(0);
    add_cfg(32'd12);
    for (k = 0; k < 270; k++) add_random(0);
    add_cfg(32'd4);
    for (k = 0; k < 270; k++) add_random(0);
    add_cfg(32'd9);
    for (k = 0; k < 270; k++) add_random(0);
    add_cfg(32'($urandom_range(0, 15)));
    for (k = 0; k < 270; k++) add_random(k >= 70);

    repeat (9) @(posedge clk);
    rst <= 0;
    wait (pending.size() == 0 && cfg_step == 0);
    @(posedge clk);
    wait (!start && awaited.size() == 0);
    repeat (300) @(posedge clk);
    if (errs == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
